FILE: rtl/whp_pkg.sv
package whp_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_CHDR = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_DATA = 3'd4,
        PH_TAIL = 3'd5,
        PH_HALT = 3'd6
    } phase_t;

    // Kind of the chunk whose header is being read
    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_FMT   = 2'd1,
        KIND_DATA  = 2'd2
    } kind_t;

    // Verdict codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF = 3'd1;
    localparam logic [2:0] ST_BOUNDS   = 3'd2;
    localparam logic [2:0] ST_FORMAT   = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_OVERSIZE = 3'd5;

    // Chunk IDs as read little-endian into a 32-bit word
    localparam logic [31:0] FOURCC_FMT  = 32'h2074_6D66;
    localparam logic [31:0] FOURCC_DATA = 32'h6174_6164;

    localparam int unsigned POS_W     = 33;
    localparam int unsigned FMT_MIN   = 16;
    localparam int unsigned HDR_LEN   = 12;
    localparam int unsigned CHDR_LEN  = 8;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam int unsigned TDATA_W = 16;

    function automatic logic [7:0] riff_magic(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h52;
            2'd1:    ch = 8'h49;
            default: ch = 8'h46;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] wave_magic(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h57;
            2'd1:    ch = 8'h41;
            2'd2:    ch = 8'h56;
            default: ch = 8'h45;
        endcase
        return ch;
    endfunction

    // Expected value of a completed fmt field, keyed by its final byte index
    function automatic logic [31:0] fmt_want(input logic [3:0] idx);
        logic [31:0] val;
        unique case (idx)
            4'd1, 4'd3, 4'd13: val = 32'd1;
            4'd7, 4'd11:       val = 32'd8000;
            4'd15:             val = 32'd8;
            default:           val = 32'd0;
        endcase
        return val;
    endfunction

    // High when the byte at idx closes an fmt field
    function automatic logic fmt_field_end(input logic [3:0] idx);
        return (idx == 4'd1) || (idx == 4'd3) || (idx == 4'd7) ||
               (idx == 4'd11) || (idx == 4'd13) || (idx == 4'd15);
    endfunction

endpackage

FILE: rtl/wave_header_parser_unit.sv
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   tdata: data_byte; tlast: last_byte
// m_        out  m_tvalid/m_tready   tdata: sample, status; tuser: sample_valid;
//                                    tlast: done_res
//
// One item in, one item out. An item is accepted every cycle as long as the
// output skid stage is free; its result is registered.
// The rate is set by the single parse step: compares and counter updates on the
// current byte and the state registers, all of them combinational.
// Reset (aresetn low, synchronous) returns the parser to the RIFF header phase
// and empties the output stages. A final byte (s_tlast) does the same for the
// parser, so the next item starts a new file.
// A stalled consumer fills the output register and then the skid register;
// s_tready drops only when both hold an item.
module wave_header_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [whp_pkg::TDATA_W-1:0] m_tdata,  // [7:0] sample, [10:8] status, rest 0
    output logic        m_tuser,    // sample_valid
    output logic        m_tlast     // done_res
);

    localparam int unsigned PW = whp_pkg::POS_W;

    // Parser state
    whp_pkg::phase_t phase_reg, phase_next;
    logic [PW-1:0]   byte_position_reg, byte_position_next;
    logic [PW-1:0]   riff_limit_reg, riff_limit_next;
    logic [PW-1:0]   chunk_remaining_reg, chunk_remaining_next;
    logic [31:0]     field_shift_reg, field_shift_next;
    logic [3:0]      field_index_reg, field_index_next;
    whp_pkg::kind_t  chunk_kind_reg, chunk_kind_next;
    logic            pad_pending_reg, pad_pending_next;
    logic            format_seen_reg, format_seen_next;
    logic            data_found_reg, data_found_next;
    logic [2:0]      error_code_reg, error_code_next;

    // Output stage and skid stage
    logic                        out_valid_reg;
    logic [whp_pkg::TDATA_W-1:0] out_data_reg;
    logic                        out_user_reg;
    logic                        out_last_reg;
    logic                        skid_valid_reg;
    logic [whp_pkg::TDATA_W-1:0] skid_data_reg;
    logic                        skid_user_reg;
    logic                        skid_last_reg;

    logic accept;
    logic pop;

    // Step intermediates
    logic [7:0]    byte_in;
    logic [1:0]    lane_sel;
    logic [31:0]   shift_or;
    logic [PW:0]   left_diff;      // riff_limit - (byte_position + 1), signed
    logic          left_neg;
    logic          left_zero;
    logic          left_lt8;
    logic [PW-1:0] chunk_total;
    logic          total_gt_left;
    logic [PW-1:0] remaining_dec;
    logic          remaining_last;
    logic          do_boundary;
    logic          do_fail;
    logic [2:0]    fail_code;

    // Result
    logic [7:0]    res_sample;
    logic          res_sample_valid;
    logic [2:0]    res_status;
    logic [whp_pkg::TDATA_W-1:0] res_data;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign byte_in  = s_tdata;

    // Byte lane within the field being assembled
    always_comb begin
        unique case (phase_reg)
            whp_pkg::PH_HDR:  lane_sel = byte_position_reg[1:0];
            whp_pkg::PH_CHDR: lane_sel = field_index_reg[1:0];
            whp_pkg::PH_FMT: begin
                if ((field_index_reg < 4'd4) || (field_index_reg >= 4'd12)) begin
                    lane_sel = {1'b0, field_index_reg[0]};
                end else begin
                    lane_sel = field_index_reg[1:0];
                end
            end
            default:          lane_sel = 2'd0;
        endcase
    end

    assign shift_or = field_shift_reg | ({24'd0, byte_in} << {lane_sel, 3'b000});

    // Bytes left before the RIFF end, counted after this byte
    assign left_diff = {1'b0, riff_limit_reg} + ~{1'b0, byte_position_reg};
    assign left_neg  = left_diff[PW];
    assign left_zero = (left_diff == '0);
    assign left_lt8  = (left_diff[PW-1:3] == '0);

    assign chunk_total   = {1'b0, shift_or} + {{(PW-1){1'b0}}, shift_or[0]};
    assign total_gt_left = left_neg || ({1'b0, chunk_total} > left_diff);

    assign remaining_dec  = (chunk_remaining_reg != '0) ?
                            (chunk_remaining_reg - {{(PW-1){1'b0}}, 1'b1}) : '0;
    assign remaining_last = (chunk_remaining_reg[PW-1:1] == '0);

    // Next state
    always_comb begin
        phase_next           = phase_reg;
        riff_limit_next      = riff_limit_reg;
        chunk_remaining_next = chunk_remaining_reg;
        field_shift_next     = field_shift_reg;
        field_index_next     = field_index_reg;
        chunk_kind_next      = chunk_kind_reg;
        pad_pending_next     = pad_pending_reg;
        format_seen_next     = format_seen_reg;
        data_found_next      = data_found_reg;
        error_code_next      = error_code_reg;
        do_boundary          = 1'b0;
        do_fail              = 1'b0;
        fail_code            = whp_pkg::ST_OK;

        // saturate the position counter
        if (byte_position_reg == whp_pkg::POS_MAX) begin
            byte_position_next = byte_position_reg;
        end else begin
            byte_position_next = byte_position_reg + {{(PW-1){1'b0}}, 1'b1};
        end

        unique case (phase_reg)
            whp_pkg::PH_HDR: begin
                unique case (byte_position_reg[3:2])
                    2'd0: begin
                        if (byte_in != whp_pkg::riff_magic(byte_position_reg[1:0])) begin
                            do_fail   = 1'b1;
                            fail_code = whp_pkg::ST_BAD_RIFF;
                        end
                    end
                    2'd1: field_shift_next = shift_or;
                    2'd2: begin
                        if (byte_in != whp_pkg::wave_magic(byte_position_reg[1:0])) begin
                            do_fail   = 1'b1;
                            fail_code = whp_pkg::ST_BAD_RIFF;
                        end else if (byte_position_reg[1:0] == 2'd3) begin
                            // header ends at byte 12: decide against limit = 8 + size
                            riff_limit_next = {1'b0, field_shift_reg} + PW'(whp_pkg::CHDR_LEN);
                            if (field_shift_reg < 32'(whp_pkg::HDR_LEN - whp_pkg::CHDR_LEN)) begin
                                do_fail   = 1'b1;
                                fail_code = whp_pkg::ST_BOUNDS;
                            end else if (field_shift_reg ==
                                         32'(whp_pkg::HDR_LEN - whp_pkg::CHDR_LEN)) begin
                                phase_next = whp_pkg::PH_TAIL;
                            end else if (field_shift_reg < 32'(whp_pkg::HDR_LEN)) begin
                                do_fail   = 1'b1;
                                fail_code = whp_pkg::ST_BOUNDS;
                            end else begin
                                phase_next       = whp_pkg::PH_CHDR;
                                field_index_next = '0;
                                field_shift_next = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            whp_pkg::PH_CHDR: begin
                field_shift_next = shift_or;
                if (field_index_reg == 4'd3) begin
                    if (shift_or == whp_pkg::FOURCC_FMT) begin
                        chunk_kind_next = whp_pkg::KIND_FMT;
                    end else if (shift_or == whp_pkg::FOURCC_DATA) begin
                        chunk_kind_next = whp_pkg::KIND_DATA;
                    end else begin
                        chunk_kind_next = whp_pkg::KIND_OTHER;
                    end
                    field_shift_next = '0;
                end
                if (field_index_reg == 4'd7) begin
                    // chunk size complete in shift_or
                    if (total_gt_left) begin
                        do_fail   = 1'b1;
                        fail_code = whp_pkg::ST_BOUNDS;
                    end else if (chunk_kind_reg == whp_pkg::KIND_FMT) begin
                        if (shift_or < 32'(whp_pkg::FMT_MIN)) begin
                            do_fail   = 1'b1;
                            fail_code = whp_pkg::ST_FORMAT;
                        end else begin
                            chunk_remaining_next = chunk_total - PW'(whp_pkg::FMT_MIN);
                            phase_next           = whp_pkg::PH_FMT;
                            field_index_next     = '0;
                            field_shift_next     = '0;
                        end
                    end else if ((chunk_kind_reg == whp_pkg::KIND_DATA) && !data_found_reg) begin
                        data_found_next = 1'b1;
                        if (shift_or == '0) begin
                            do_fail   = 1'b1;
                            fail_code = whp_pkg::ST_MISSING;
                        end else begin
                            chunk_remaining_next = {1'b0, shift_or};
                            pad_pending_next     = shift_or[0];
                            phase_next           = whp_pkg::PH_DATA;
                        end
                    end else if (chunk_total == '0) begin
                        do_boundary = 1'b1;
                    end else begin
                        chunk_remaining_next = chunk_total;
                        phase_next           = whp_pkg::PH_SKIP;
                    end
                end else begin
                    field_index_next = field_index_reg + 4'd1;
                end
            end

            whp_pkg::PH_FMT: begin
                field_shift_next = shift_or;
                if (whp_pkg::fmt_field_end(field_index_reg) &&
                    (shift_or != whp_pkg::fmt_want(field_index_reg))) begin
                    do_fail   = 1'b1;
                    fail_code = whp_pkg::ST_FORMAT;
                end else begin
                    if (whp_pkg::fmt_field_end(field_index_reg)) begin
                        field_shift_next = '0;
                    end
                    if (field_index_reg == 4'd15) begin
                        format_seen_next = 1'b1;
                        if (chunk_remaining_reg == '0) begin
                            do_boundary = 1'b1;
                        end else begin
                            phase_next = whp_pkg::PH_SKIP;
                        end
                    end else begin
                        field_index_next = field_index_reg + 4'd1;
                    end
                end
            end

            whp_pkg::PH_SKIP: begin
                chunk_remaining_next = remaining_dec;
                if (remaining_last) begin
                    do_boundary = 1'b1;
                end
            end

            whp_pkg::PH_DATA: begin
                chunk_remaining_next = remaining_dec;
                if (remaining_last) begin
                    if (pad_pending_reg) begin
                        // drop the pad byte through the skip phase
                        pad_pending_next     = 1'b0;
                        chunk_remaining_next = {{(PW-1){1'b0}}, 1'b1};
                        phase_next           = whp_pkg::PH_SKIP;
                    end else begin
                        do_boundary = 1'b1;
                    end
                end
            end

            default: ;
        endcase

        // Next chunk header, end of RIFF, or a header that cannot fit
        if (do_boundary) begin
            if (left_zero) begin
                phase_next = whp_pkg::PH_TAIL;
            end else if (left_neg || left_lt8) begin
                do_fail   = 1'b1;
                fail_code = whp_pkg::ST_BOUNDS;
            end else begin
                phase_next       = whp_pkg::PH_CHDR;
                field_index_next = '0;
                field_shift_next = '0;
            end
        end

        if (do_fail) begin
            error_code_next = fail_code;
            phase_next      = whp_pkg::PH_HALT;
        end
    end

    // Result of this item
    always_comb begin
        res_sample_valid = (phase_reg == whp_pkg::PH_DATA);
        res_sample       = res_sample_valid ? byte_in : 8'd0;
        res_status       = whp_pkg::ST_OK;
        if (s_tlast) begin
            priority if (byte_position_next[PW-1]) begin
                res_status = whp_pkg::ST_OVERSIZE;
            end else if (error_code_next != whp_pkg::ST_OK) begin
                res_status = error_code_next;
            end else if (phase_next == whp_pkg::PH_HDR) begin
                res_status = whp_pkg::ST_BAD_RIFF;
            end else if (phase_next != whp_pkg::PH_TAIL) begin
                res_status = whp_pkg::ST_BOUNDS;
            end else if (!format_seen_next || !data_found_next) begin
                res_status = whp_pkg::ST_MISSING;
            end else begin
                res_status = whp_pkg::ST_OK;
            end
        end
        res_data = {(whp_pkg::TDATA_W - 11)'(0), res_status, res_sample};
    end

    // Parser state registers; the final byte restarts for a new file
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            phase_reg           <= whp_pkg::PH_HDR;
            byte_position_reg   <= '0;
            riff_limit_reg      <= '0;
            chunk_remaining_reg <= '0;
            field_shift_reg     <= '0;
            field_index_reg     <= '0;
            chunk_kind_reg      <= whp_pkg::KIND_OTHER;
            pad_pending_reg     <= 1'b0;
            format_seen_reg     <= 1'b0;
            data_found_reg      <= 1'b0;
            error_code_reg      <= whp_pkg::ST_OK;
        end else if (accept) begin
            phase_reg           <= phase_next;
            byte_position_reg   <= byte_position_next;
            riff_limit_reg      <= riff_limit_next;
            chunk_remaining_reg <= chunk_remaining_next;
            field_shift_reg     <= field_shift_next;
            field_index_reg     <= field_index_next;
            chunk_kind_reg      <= chunk_kind_next;
            pad_pending_reg     <= pad_pending_next;
            format_seen_reg     <= format_seen_next;
            data_found_reg      <= data_found_next;
            error_code_reg      <= error_code_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // input is stalled; advance the skid item on a pop
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
                out_last_reg <= skid_last_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= res_data;
                out_user_reg <= res_sample_valid;
                out_last_reg <= s_tlast;
            end else begin
                skid_data_reg <= res_data;
                skid_user_reg <= res_sample_valid;
                skid_last_reg <= s_tlast;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // Skid stage is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while output register is empty");

    // A final byte restarts the parser
    a_restart_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (phase_reg == whp_pkg::PH_HDR) &&
                                (byte_position_reg == '0) &&
                                (error_code_reg == whp_pkg::ST_OK))
        else $error("parser did not restart after final byte");

    // Halt phase and latched error go together
    a_halt_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == whp_pkg::PH_HALT) == (error_code_reg != whp_pkg::ST_OK))
        else $error("halt phase and error code disagree");

    // A latched error holds until the file ends
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_tlast && (error_code_reg != whp_pkg::ST_OK)) |=>
            (error_code_reg == $past(error_code_reg)))
        else $error("latched error changed within a file");

endmodule
